@@ design/mrm_pkg.sv @@
package mrm_pkg;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  SLAVE_DEFAULT   = 8'h01;
    localparam logic [7:0]  SLAVE_MAX       = 8'd247;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TX       = 6'b000010,
        ST_SC_START = 6'b000100,
        ST_SC_BODY  = 6'b001000,
        ST_SC_EMIT  = 6'b010000,
        ST_SC_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [4:0]  frame_offset;
        logic [7:0]  reply_fn;
        logic [7:0]  byte_count;
        logic [15:0] register_value;
        logic        value_valid;
        logic [5:0]  received_count;
    } t_result;

    // One byte of CRC-16/Modbus, reflected, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ design/mrm_req_if.sv @@
interface mrm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] write_value;
    logic        write_op;
    logic [7:0]  rx_byte;

    modport source (output valid, output opcode, output slave_address,
                    output register_address, output write_value, output write_op,
                    output rx_byte, input ready);
    modport sink   (input valid, input opcode, input slave_address,
                    input register_address, input write_value, input write_op,
                    input rx_byte, output ready);
endinterface

@@ design/mrm_rsp_if.sv @@
interface mrm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [4:0]  frame_offset;
    logic [7:0]  reply_fn;
    logic [7:0]  byte_count;
    logic [15:0] register_value;
    logic        value_valid;
    logic [5:0]  received_count;

    modport source (output valid, output kind, output tx_byte, output last,
                    output frame_offset, output reply_fn, output byte_count,
                    output register_value, output value_valid, output received_count,
                    input ready);
    modport sink   (input valid, input kind, input tx_byte, input last,
                    input frame_offset, input reply_fn, input byte_count,
                    input register_value, input value_valid, input received_count,
                    output ready);
endinterface

@@ design/modbus_rtu_master_frame_engine_top.sv @@
// Modbus RTU master frame engine. A request transaction (opcode 0) clamps the
// slave address to 1..247, empties the receive store and produces eight
// transmit results: slave, function (6 write, 3 read), register, value or a
// count of one, then the CRC-16/Modbus low byte first, one byte per cycle
// when the output is not stalled. A received byte transaction (opcode 1)
// appends to the store; bytes past RX_DEPTH are dropped. A close transaction
// (opcode 2) scans every start offset for a frame addressed from the last
// requested slave with function 3 or 6, takes its third byte as the count,
// checks the CRC and reports each good frame, then a done result with last
// set. The scan streams the store through its single read port, one byte a
// cycle: an offset that fails at its address, function or count byte goes
// back to the start state, and a candidate frame is read through its CRC
// and, if good, reported from the emit state before the next offset. Function
// 6 replies are scanned the same way, with the register high byte read as the
// count. New transactions are accepted only while the engine is idle; a
// pending result in the output register does not hold off acceptance. Opcode
// 3 is accepted and ignored.
module modbus_rtu_master_frame_engine_top #(
    parameter int RX_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrm_req_if.sink   i_req,
    mrm_rsp_if.source o_rsp
);
    localparam int AW = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);
    // Wide enough for offset + 5 + count.
    localparam int SW = ((CW > 8) ? CW : 8) + 2;

    mrm_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [7:0]       r_target, n_target;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_fr [6];
    logic [2:0]       r_idx, n_idx;

    logic [AW-1:0]    r_off, n_off;
    logic [8:0]       r_j, n_j;
    logic [7:0]       r_fn, n_fn;
    logic [7:0]       r_bc, n_bc;
    logic [15:0]      r_val, n_val;
    logic [7:0]       r_lo, n_lo;
    logic [15:0]      r_scrc, n_scrc;

    logic             r_ov, n_ov;
    mrm_pkg::t_result r_res, n_res;

    logic             in_fire;
    logic             slot_free;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic [7:0]       slave_clamped;
    logic [7:0]       fn_req;

    assign in_fire   = i_req.valid && i_req.ready;
    assign slot_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == mrm_pkg::ST_IDLE);

    assign wr_en = in_fire && (i_req.opcode == mrm_pkg::OP_RX_BYTE)
                   && (r_cnt < CW'(RX_DEPTH));

    assign slave_clamped = (i_req.slave_address == 8'd0
                            || i_req.slave_address > mrm_pkg::SLAVE_MAX)
                           ? mrm_pkg::SLAVE_DEFAULT : i_req.slave_address;
    assign fn_req = i_req.write_op ? mrm_pkg::FN_WRITE_SINGLE : mrm_pkg::FN_READ_HOLDING;

    // The scan start state reads the first byte of an offset; the body state
    // keeps one read in flight for the following byte.
    always_comb begin
        if (r_state == mrm_pkg::ST_SC_BODY) begin
            rd_addr = r_off + AW'(r_j) + AW'(1);
        end else begin
            rd_addr = r_off;
        end
    end

    mrm_rx_store #(
        .RX_DEPTH (RX_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (i_req.rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        logic [SW-1:0] frame_end;
        logic [8:0]    crc_end;
        logic [7:0]    tx;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_target = r_target;
        n_crc    = r_crc;
        n_idx    = r_idx;
        n_off    = r_off;
        n_j      = r_j;
        n_fn     = r_fn;
        n_bc     = r_bc;
        n_val    = r_val;
        n_lo     = r_lo;
        n_scrc   = r_scrc;
        n_ov     = r_ov;
        n_res    = r_res;
        frame_end = SW'(r_off) + SW'(5) + SW'(rd_data);
        crc_end   = {1'b0, r_bc} + 9'd3;
        tx        = 8'h00;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            mrm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_req.opcode)
                        mrm_pkg::OP_REQUEST: begin
                            n_target = slave_clamped;
                            n_cnt    = '0;
                            n_crc    = mrm_pkg::CRC_INIT;
                            n_idx    = '0;
                            n_state  = mrm_pkg::ST_TX;
                        end
                        mrm_pkg::OP_RX_BYTE: begin
                            if (r_cnt < CW'(RX_DEPTH)) begin
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        mrm_pkg::OP_CLOSE: begin
                            n_off   = '0;
                            n_state = mrm_pkg::ST_SC_START;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mrm_pkg::ST_TX: begin
                if (slot_free) begin
                    if (r_idx < 3'd6) begin
                        tx    = r_fr[r_idx];
                        n_crc = mrm_pkg::crc_byte(r_crc, r_fr[r_idx]);
                    end else if (r_idx == 3'd6) begin
                        tx = r_crc[7:0];
                    end else begin
                        tx = r_crc[15:8];
                    end
                    n_ov                 = 1'b1;
                    n_res                = '0;
                    n_res.kind           = mrm_pkg::KIND_TX;
                    n_res.tx_byte        = tx;
                    n_res.last           = (r_idx == 3'd7);
                    n_res.received_count = 6'(r_cnt);
                    n_idx                = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = mrm_pkg::ST_IDLE;
                    end
                end
            end
            mrm_pkg::ST_SC_START: begin
                if (SW'(r_off) + SW'(4) < SW'(r_cnt)) begin
                    n_j     = '0;
                    n_scrc  = mrm_pkg::CRC_INIT;
                    n_state = mrm_pkg::ST_SC_BODY;
                end else begin
                    n_state = mrm_pkg::ST_SC_DONE;
                end
            end
            mrm_pkg::ST_SC_BODY: begin
                n_j = r_j + 9'd1;
                // Bytes 0 through 2 + count are covered by the CRC.
                if (r_j <= 9'd2 || r_j < crc_end) begin
                    n_scrc = mrm_pkg::crc_byte(r_scrc, rd_data);
                end
                if (r_j == 9'd3) begin
                    n_val[15:8] = rd_data;
                end
                if (r_j == 9'd4) begin
                    n_val[7:0] = rd_data;
                end
                if (r_j == 9'd0) begin
                    if (rd_data != r_target) begin
                        n_off   = r_off + AW'(1);
                        n_state = mrm_pkg::ST_SC_START;
                    end
                end else if (r_j == 9'd1) begin
                    n_fn = rd_data;
                    if (rd_data != mrm_pkg::FN_READ_HOLDING
                        && rd_data != mrm_pkg::FN_WRITE_SINGLE) begin
                        n_off   = r_off + AW'(1);
                        n_state = mrm_pkg::ST_SC_START;
                    end
                end else if (r_j == 9'd2) begin
                    n_bc = rd_data;
                    if (frame_end > SW'(r_cnt)) begin
                        n_off   = r_off + AW'(1);
                        n_state = mrm_pkg::ST_SC_START;
                    end
                end else if (r_j == crc_end) begin
                    n_lo = rd_data;
                end else if (r_j == crc_end + 9'd1) begin
                    if ({rd_data, r_lo} == r_scrc) begin
                        n_state = mrm_pkg::ST_SC_EMIT;
                    end else begin
                        n_off   = r_off + AW'(1);
                        n_state = mrm_pkg::ST_SC_START;
                    end
                end
            end
            mrm_pkg::ST_SC_EMIT: begin
                if (slot_free) begin
                    n_ov                 = 1'b1;
                    n_res                = '0;
                    n_res.kind           = mrm_pkg::KIND_FRAME;
                    n_res.frame_offset   = 5'(r_off);
                    n_res.reply_fn       = r_fn;
                    n_res.byte_count     = r_bc;
                    n_res.received_count = 6'(r_cnt);
                    if (r_fn == mrm_pkg::FN_READ_HOLDING && r_bc == 8'd2) begin
                        n_res.value_valid    = 1'b1;
                        n_res.register_value = r_val;
                    end
                    n_off   = r_off + AW'(1);
                    n_state = mrm_pkg::ST_SC_START;
                end
            end
            mrm_pkg::ST_SC_DONE: begin
                if (slot_free) begin
                    n_ov                 = 1'b1;
                    n_res                = '0;
                    n_res.kind           = mrm_pkg::KIND_DONE;
                    n_res.last           = 1'b1;
                    n_res.received_count = 6'(r_cnt);
                    n_state              = mrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mrm_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_target <= mrm_pkg::SLAVE_DEFAULT;
            r_crc    <= mrm_pkg::CRC_INIT;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_target <= n_target;
            r_crc    <= n_crc;
            r_ov     <= n_ov;
        end
    end

    // Payload and scan working registers need no reset.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_off  <= n_off;
        r_j    <= n_j;
        r_fn   <= n_fn;
        r_bc   <= n_bc;
        r_val  <= n_val;
        r_lo   <= n_lo;
        r_scrc <= n_scrc;
        r_res  <= n_res;
        if (in_fire && i_req.opcode == mrm_pkg::OP_REQUEST) begin
            r_fr[0] <= slave_clamped;
            r_fr[1] <= fn_req;
            r_fr[2] <= i_req.register_address[15:8];
            r_fr[3] <= i_req.register_address[7:0];
            r_fr[4] <= i_req.write_op ? i_req.write_value[15:8] : 8'h00;
            r_fr[5] <= i_req.write_op ? i_req.write_value[7:0] : 8'h01;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.kind           = r_res.kind;
    assign o_rsp.tx_byte        = r_res.tx_byte;
    assign o_rsp.last           = r_res.last;
    assign o_rsp.frame_offset   = r_res.frame_offset;
    assign o_rsp.reply_fn       = r_res.reply_fn;
    assign o_rsp.byte_count     = r_res.byte_count;
    assign o_rsp.register_value = r_res.register_value;
    assign o_rsp.value_valid    = r_res.value_valid;
    assign o_rsp.received_count = r_res.received_count;
endmodule

@@ design/mrm_rx_store.sv @@
// Receive byte store: one write port, one read port with registered data.
module mrm_rx_store #(
    parameter int RX_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(RX_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                  i_wr_data,
    input  logic [$clog2(RX_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);
    logic [7:0] r_mem [RX_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
